// File: src/emg_tfe_pkg.sv
package emg_tfe_pkg;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] rms;
    logic [15:0] mav;
    logic [23:0] wave_length;
    logic [7:0]  zero_crossings;
    logic [7:0]  slope_changes;
    logic [1:0]  status;
  } out_item_t;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusShort = 2'd1;
  localparam logic [1:0] StatusLong  = 2'd2;

  localparam logic [23:0] WlMax  = 24'hFFFFFF;
  localparam logic [7:0]  CntMax = 8'hFF;

  localparam int unsigned AbsW = 29;
  localparam int unsigned SqW  = 44;
  localparam int unsigned CntW = 13;

  // A closed window handed from the accumulator to the back end.
  typedef struct packed {
    logic [SqW-1:0]  square_sum;
    logic [AbsW-1:0] abs_sum;
    logic [CntW-1:0] count;
    logic [23:0]     wave_length;
    logic [7:0]      zero_crossings;
    logic [7:0]      slope_changes;
    logic            overflowed;
  } window_t;

endpackage

// File: src/emg_tfe_front.sv
module emg_tfe_front #(
  parameter int unsigned WindowMax = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  emg_tfe_pkg::in_item_t    item_i,
  input  logic [14:0]              zc_thr_i,
  input  logic [15:0]              ssc_thr_i,
  input  logic                     q_full_i,
  output logic                     stall_o,
  output logic                     win_valid_o,
  output emg_tfe_pkg::window_t     win_o
);

  localparam int unsigned CW = emg_tfe_pkg::CntW;

  logic signed [15:0] prev_q;
  logic signed [16:0] pslope_q;
  logic [CW-1:0] cnt_q;
  logic [emg_tfe_pkg::AbsW-1:0] abs_q;
  logic [emg_tfe_pkg::SqW-1:0] sq_q;
  logic [23:0] wl_q;
  logic [7:0] zc_q, ssc_q;
  logic ovf_q;

  logic signed [16:0] s, slope;
  logic [15:0] abs_s;
  logic [16:0] abs_slope;
  logic [24:0] wl_sum;
  logic [31:0] sq;
  logic zc_hit, ssc_hit, take;
  logic signed [17:0] zt, st;
  logic signed [17:0] a18, b18;
  logic signed [18:0] sd;
  logic [18:0] abs_sd;
  logic [17:0] abs_zd;

  assign stall_o = q_full_i;
  assign take    = cnt_q < CW'(WindowMax);

  always_comb begin
    s         = 17'(item_i.sample);
    slope     = s - 17'(prev_q);
    abs_s     = item_i.sample[15] ? 16'(-s) : item_i.sample;
    abs_slope = slope[16] ? 17'(-slope) : slope;
    wl_sum    = {1'b0, wl_q} + 25'(abs_slope);
    sq        = 32'($signed(item_i.sample) * $signed(item_i.sample));
    zt        = 18'({3'b0, zc_thr_i});
    st        = 18'({2'b0, ssc_thr_i});
    a18       = 18'(prev_q);
    b18       = 18'(s);
    abs_zd    = slope[16] ? 18'(-slope) : 18'(slope);
    zc_hit    = ((a18 > zt && b18 < -zt) || (a18 < -zt && b18 > zt))
                && (abs_zd >= 18'(zt));
    sd        = 19'(pslope_q) - 19'(slope);
    abs_sd    = sd[18] ? 19'(-sd) : 19'(sd);
    ssc_hit   = ((18'(pslope_q) > st && 18'(slope) < -st) ||
                 (18'(pslope_q) < -st && 18'(slope) > st))
                && (abs_sd >= 19'(st));
  end

  always_comb begin
    win_o.square_sum     = sq_q + emg_tfe_pkg::SqW'(sq);
    win_o.abs_sum        = abs_q + emg_tfe_pkg::AbsW'(abs_s);
    win_o.count          = cnt_q + CW'(1);
    win_o.wave_length    = wl_q;
    win_o.zero_crossings = zc_q;
    win_o.slope_changes  = ssc_q;
    win_o.overflowed     = ovf_q;
    if (take && cnt_q != '0) begin
      win_o.wave_length = wl_sum[24] ? emg_tfe_pkg::WlMax : wl_sum[23:0];
      if (zc_hit && zc_q != emg_tfe_pkg::CntMax) win_o.zero_crossings = zc_q + 8'd1;
      if (cnt_q >= CW'(2) && ssc_hit && ssc_q != emg_tfe_pkg::CntMax)
        win_o.slope_changes = ssc_q + 8'd1;
    end
    if (!take) begin
      win_o.square_sum = sq_q;
      win_o.abs_sum    = abs_q;
      win_o.count      = cnt_q;
      win_o.overflowed = 1'b1;
    end
    win_valid_o = valid_i && !q_full_i && item_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0; pslope_q <= '0; cnt_q <= '0; abs_q <= '0; sq_q <= '0;
      wl_q <= '0; zc_q <= '0; ssc_q <= '0; ovf_q <= 1'b0;
    end else if (valid_i && !q_full_i) begin
      if (item_i.last) begin
        prev_q <= '0; pslope_q <= '0; cnt_q <= '0; abs_q <= '0; sq_q <= '0;
        wl_q <= '0; zc_q <= '0; ssc_q <= '0; ovf_q <= 1'b0;
      end else begin
        if (take) begin
          prev_q <= item_i.sample;
          if (cnt_q != '0) pslope_q <= slope;
        end
        cnt_q <= win_o.count; abs_q <= win_o.abs_sum; sq_q <= win_o.square_sum;
        wl_q <= win_o.wave_length; zc_q <= win_o.zero_crossings;
        ssc_q <= win_o.slope_changes; ovf_q <= win_o.overflowed;
      end
    end
  end

endmodule

// File: src/emg_tfe_queue.sv
module emg_tfe_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  emg_tfe_pkg::window_t data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output emg_tfe_pkg::window_t data_o
);

  emg_tfe_pkg::window_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wp_q <= !wp_q;
      if (pop_i && valid_o) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i && !full_o) - 2'(pop_i && valid_o);
    end
  end

endmodule

// File: src/emg_tfe_back.sv
module emg_tfe_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   win_valid_i,
  input  emg_tfe_pkg::window_t   win_i,
  output logic                   win_pop_o,
  output logic                   empty_o,
  input  logic                   pop_i,
  output emg_tfe_pkg::out_item_t item_o
);

  localparam int unsigned SqW = emg_tfe_pkg::SqW;
  localparam int unsigned CW  = emg_tfe_pkg::CntW;

  typedef enum logic [2:0] {Idle, DivSq, DivAbs, Root, Done} state_e;

  state_e state_q;
  logic [5:0] step_q;
  logic [SqW-1:0] num_q, quo_q;
  logic [CW:0] rem_q;
  logic [CW-1:0] den_q;
  logic [SqW-1:0] sqmean_q;
  logic [31:0] rv_q;
  logic [16:0] rrem_q;
  logic [15:0] root_q;
  emg_tfe_pkg::out_item_t res_q;

  logic [CW:0] rem_sh;
  logic [18:0] rtrial;
  logic [18:0] rsh;

  assign empty_o = state_q != Done;
  assign win_pop_o = state_q == Idle && win_valid_i;
  assign item_o = res_q;

  always_comb begin
    rem_sh = {rem_q[CW-1:0], num_q[SqW-1]};
    rsh    = {rrem_q, rv_q[31:30]};
    rtrial = {1'b0, root_q, 2'b01};
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      Idle: begin
        num_q <= win_i.square_sum; den_q <= win_i.count; rem_q <= '0;
        step_q <= '0;
        res_q.wave_length    <= win_i.wave_length;
        res_q.zero_crossings <= win_i.zero_crossings;
        res_q.slope_changes  <= win_i.slope_changes;
        res_q.status <= win_i.overflowed ? emg_tfe_pkg::StatusLong : emg_tfe_pkg::StatusOk;
        quo_q <= SqW'(win_i.abs_sum);
        if (win_i.count < CW'(3)) begin
          res_q <= '0;
          res_q.status <= emg_tfe_pkg::StatusShort;
        end
      end
      DivSq, DivAbs: begin
        num_q <= {num_q[SqW-2:0], 1'b0};
        if (rem_sh >= {1'b0, den_q}) begin
          rem_q <= rem_sh - {1'b0, den_q};
          num_q[0] <= 1'b1;
        end else begin
          rem_q <= rem_sh;
        end
        step_q <= step_q + 6'd1;
        if (step_q == 6'(SqW - 1)) begin
          step_q <= '0; rem_q <= '0;
          if (state_q == DivSq) begin
            num_q <= quo_q;
            sqmean_q <= {num_q[SqW-2:0], rem_sh >= {1'b0, den_q}};
          end else begin
            res_q.mav <= 16'({num_q[SqW-2:0], rem_sh >= {1'b0, den_q}});
            rv_q <= 32'(sqmean_q); rrem_q <= '0; root_q <= '0;
          end
        end
      end
      Root: begin
        rv_q <= {rv_q[29:0], 2'b00};
        step_q <= step_q + 6'd1;
        if (rsh >= rtrial) begin
          rrem_q <= 17'(rsh - rtrial); root_q <= {root_q[14:0], 1'b1};
        end else begin
          rrem_q <= 17'(rsh); root_q <= {root_q[14:0], 1'b0};
        end
        if (step_q == 6'd15)
          res_q.rms <= {root_q[14:0], rsh >= rtrial};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
    end else begin
      unique case (state_q)
        Idle:   if (win_valid_i) state_q <= (win_i.count < CW'(3)) ? Done : DivSq;
        DivSq:  if (step_q == 6'(SqW - 1)) state_q <= DivAbs;
        DivAbs: if (step_q == 6'(SqW - 1)) state_q <= Root;
        Root:   if (step_q == 6'd15) state_q <= Done;
        Done:   if (pop_i) state_q <= Idle;
        default: state_q <= Idle;
      endcase
    end
  end

endmodule

// File: src/emg_time_feature_extractor.sv
// Channel   | Handshake          | Payload
// input     | push_i / full_o    | in_item_i  (sample, last)
// result    | empty_o / pop_i    | out_item_o (rms, mav, wave_length, zero_crossings,
//           |                    |             slope_changes, status)
// config    | APB psel/penable   | zc_threshold at 0x0, ssc_threshold at 0x4
//
// Samples are accepted one per cycle; a sample is folded into the window sums
// in the cycle it is accepted. A closed window enters a two-entry queue, and
// the back end then runs a load, two 44-step restoring divisions and a 16-step
// square root before the result shows; a window of under three samples skips
// straight to a short status. Input stalls only while that queue is full.
// Reset clears all window state and both thresholds to zero.
module emg_time_feature_extractor #(
  parameter int unsigned WindowMax = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  output logic                   full_o,
  input  emg_tfe_pkg::in_item_t  in_item_i,
  output logic                   empty_o,
  input  logic                   pop_i,
  output emg_tfe_pkg::out_item_t out_item_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [14:0] zc_thr_q;
  logic [15:0] ssc_thr_q;
  logic q_full, q_valid, win_push, win_pop;
  emg_tfe_pkg::window_t win_in, win_out;

  assign pready = 1'b1;

  // Two registers; the address selects by its word bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zc_thr_q  <= '0;
      ssc_thr_q <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == 1'b0) zc_thr_q <= pwdata[14:0];
      else ssc_thr_q <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = paddr[2] ? {16'b0, ssc_thr_q} : {17'b0, zc_thr_q};
  end

  emg_tfe_front #(.WindowMax(WindowMax)) u_front (
    .clk_i, .rst_ni, .valid_i(push_i), .item_i(in_item_i),
    .zc_thr_i(zc_thr_q), .ssc_thr_i(ssc_thr_q), .q_full_i(q_full),
    .stall_o(full_o), .win_valid_o(win_push), .win_o(win_in)
  );

  emg_tfe_queue u_queue (
    .clk_i, .rst_ni, .push_i(win_push), .data_i(win_in), .full_o(q_full),
    .pop_i(win_pop), .valid_o(q_valid), .data_o(win_out)
  );

  emg_tfe_back u_back (
    .clk_i, .rst_ni, .win_valid_i(q_valid), .win_i(win_out), .win_pop_o(win_pop),
    .empty_o, .pop_i, .item_o(out_item_o)
  );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned WinMax = 256;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned DrainCycles = 150;
  localparam logic [2:0] AddrZcThr = 3'd0;
  localparam logic [2:0] AddrSscThr = 3'd4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push_i = 1'b0;
  logic pop_i = 1'b0;
  emg_tfe_pkg::in_item_t in_item_i = '0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic full_o;
  logic empty_o;
  emg_tfe_pkg::out_item_t out_item_o;
  logic [31:0] prdata;
  logic pready;

  emg_time_feature_extractor dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push_i), .full_o(full_o),
    .in_item_i(in_item_i), .empty_o(empty_o), .pop_i(pop_i), .out_item_o(out_item_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Thresholds as the block should hold them.
  logic [14:0] zc_thr;
  logic [15:0] ssc_thr;

  // Window state of the local model.
  int prev_sample;
  int prev_slope;
  int unsigned win_count;
  longint unsigned abs_acc;
  longint unsigned square_acc;
  int unsigned length_acc;
  int unsigned crossing_acc;
  int unsigned slope_change_acc;
  bit win_overflow;

  emg_tfe_pkg::out_item_t pending_results[$];
  // One entry per closing sample: a hand-written feature set, if the row has one.
  bit typed_valid_q[$];
  emg_tfe_pkg::out_item_t typed_result_q[$];

  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  bit calm = 1'b0;

  typedef struct {
    logic signed [15:0]     sample;
    logic                   last;
    bit                     typed;
    emg_tfe_pkg::out_item_t result;
  } stim_row_t;

  task automatic report(input string what, input longint got, input longint want);
    error_count++;
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic int unsigned mag(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // Floored square root, built bit by bit from the top.
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 20; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // True when a and b sit on opposite sides of the dead band [-t, t] and are
  // at least t apart.
  function automatic bit crosses_band(input int a, input int b, input int t);
    return ((a > t && b < -t) || (a < -t && b > t)) && mag(a - b) >= t;
  endfunction

  function automatic void clear_window();
    prev_sample = 0;
    prev_slope = 0;
    win_count = 0;
    abs_acc = 0;
    square_acc = 0;
    length_acc = 0;
    crossing_acc = 0;
    slope_change_acc = 0;
    win_overflow = 1'b0;
  endfunction

  // Folds one accepted sample into the model; a closing sample yields the
  // feature set of the window.
  function automatic bit fold_sample(input emg_tfe_pkg::in_item_t item,
                                     output emg_tfe_pkg::out_item_t feat);
    int s;
    int slope;
    s = item.sample;
    feat = '0;
    if (win_count < WinMax) begin
      if (win_count >= 1) begin
        slope = s - prev_sample;
        length_acc = length_acc + mag(slope);
        if (length_acc > emg_tfe_pkg::WlMax) length_acc = emg_tfe_pkg::WlMax;
        if (crosses_band(prev_sample, s, int'(zc_thr)) &&
            crossing_acc < emg_tfe_pkg::CntMax)
          crossing_acc++;
        if (win_count >= 2 && crosses_band(prev_slope, slope, int'(ssc_thr)) &&
            slope_change_acc < emg_tfe_pkg::CntMax)
          slope_change_acc++;
        prev_slope = slope;
      end
      abs_acc += mag(s);
      square_acc += longint'(s) * longint'(s);
      prev_sample = s;
      win_count++;
    end else begin
      win_overflow = 1'b1;
    end
    if (!item.last) return 1'b0;
    if (win_count < 3) begin
      feat.status = emg_tfe_pkg::StatusShort;
    end else begin
      feat.rms = 16'(floor_sqrt(square_acc / win_count));
      feat.mav = 16'(abs_acc / win_count);
      feat.wave_length = 24'(length_acc);
      feat.zero_crossings = 8'(crossing_acc);
      feat.slope_changes = 8'(slope_change_acc);
      feat.status = win_overflow ? emg_tfe_pkg::StatusLong : emg_tfe_pkg::StatusOk;
    end
    clear_window();
    return 1'b1;
  endfunction

  // Accepted items and results are both taken from the values seen just
  // before the clock edge, so nothing here races with the drivers.
  always @(posedge clk_i) begin
    emg_tfe_pkg::out_item_t feat;
    emg_tfe_pkg::out_item_t want;
    bit typed;
    if (rst_ni) begin
      if (push_i && !full_o) begin
        if (fold_sample(in_item_i, feat)) begin
          typed = typed_valid_q.pop_front();
          want = typed_result_q.pop_front();
          pending_results.push_back(typed ? want : feat);
        end
      end
      if (pop_i && !empty_o) begin
        if (pending_results.size() == 0) begin
          report("unexpected result", out_item_o.status, -1);
        end else begin
          want = pending_results.pop_front();
          if (out_item_o.rms !== want.rms) report("rms", out_item_o.rms, want.rms);
          if (out_item_o.mav !== want.mav) report("mav", out_item_o.mav, want.mav);
          if (out_item_o.wave_length !== want.wave_length)
            report("wave_length", out_item_o.wave_length, want.wave_length);
          if (out_item_o.zero_crossings !== want.zero_crossings)
            report("zero_crossings", out_item_o.zero_crossings, want.zero_crossings);
          if (out_item_o.slope_changes !== want.slope_changes)
            report("slope_changes", out_item_o.slope_changes, want.slope_changes);
          if (out_item_o.status !== want.status)
            report("status", out_item_o.status, want.status);
        end
      end
    end
  end

  // The result side stalls in random bursts, except in the calm last phase.
  always @(posedge clk_i) begin
    int unsigned stall_left;
    if (!calm && stall_left == 0 && $urandom_range(0, 9) == 0)
      stall_left = $urandom_range(1, 14);
    if (!calm && stall_left > 0) begin
      pop_i <= 1'b0;
      stall_left--;
    end else begin
      pop_i <= 1'b1;
    end
  end

  // Watchdog: too long without any item moving ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (push_i && !full_o) || (pop_i && !empty_o) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("testbench: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (addr == AddrZcThr) zc_thr = data[14:0];
    else ssc_thr = data[15:0];
    // Read the register back.
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== ((addr == AddrZcThr) ? {17'd0, zc_thr} : {16'd0, ssc_thr}))
      report("register readback", prdata, (addr == AddrZcThr) ? zc_thr : ssc_thr);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Thresholds change only once every result is out and the block is quiet.
  task automatic set_thresholds(input logic [31:0] zc, input logic [31:0] ssc);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    apb_write(AddrZcThr, zc);
    apb_write(AddrSscThr, ssc);
  endtask

  task automatic push_sample(input logic signed [15:0] s, input logic last,
                             input bit typed, input emg_tfe_pkg::out_item_t result);
    if (last) begin
      typed_valid_q.push_back(typed);
      typed_result_q.push_back(result);
    end
    if (!calm && $urandom_range(0, 7) == 0) begin
      push_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    push_i <= 1'b1;
    in_item_i <= '{sample: s, last: last};
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
  endtask

  // Sample source: full range, small values, a moderate range, values around the
  // zero-crossing band edge, and the two extremes.
  function automatic logic signed [15:0] draw_sample();
    int v;
    case ($urandom_range(0, 4))
      0: v = $urandom_range(0, 65535) - 32768;
      1: v = int'($urandom_range(0, 600)) - 300;
      2: begin
        v = int'(zc_thr) + int'($urandom_range(0, 6)) - 3;
        if ($urandom_range(0, 1)) v = -v;
      end
      3: v = $urandom_range(0, 1) ? 32767 : -32768;
      default: v = int'($urandom_range(0, 8000)) - 4000;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  task automatic random_windows(input int unsigned items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(0, 19))
        0: len = $urandom_range(1, 2);
        1: len = $urandom_range(250, 300);
        default: len = $urandom_range(3, 40);
      endcase
      for (int unsigned k = 1; k <= len; k++)
        push_sample(draw_sample(), k == len, 1'b0, '0);
      sent += (len > WinMax) ? WinMax : len;
    end
    push_i <= 1'b0;
  endtask

  initial begin
    stim_row_t rows[$];
    emg_tfe_pkg::out_item_t short_win;
    short_win = '0;
    short_win.status = emg_tfe_pkg::StatusShort;
    zc_thr = '0;
    ssc_thr = '0;
    clear_window();

    // Directed part, thresholds at their reset value of zero.
    // A one-sample window and a two-sample window of the extremes are short.
    rows.push_back('{16'sd100, 1'b1, 1'b1, short_win});
    rows.push_back('{-16'sd32768, 1'b0, 1'b0, '0});
    rows.push_back('{16'sd32767, 1'b1, 1'b1, short_win});
    // Full-swing three-sample window: two crossings and one slope change.
    rows.push_back('{-16'sd32768, 1'b0, 1'b0, '0});
    rows.push_back('{16'sd32767, 1'b0, 1'b0, '0});
    rows.push_back('{-16'sd32768, 1'b1, 1'b1,
                     '{16'd32767, 16'd32767, 24'd131070, 8'd2, 8'd1,
                       emg_tfe_pkg::StatusOk}});
    // An all-zero window of minimum length.
    rows.push_back('{16'sd0, 1'b0, 1'b0, '0});
    rows.push_back('{16'sd0, 1'b0, 1'b0, '0});
    rows.push_back('{16'sd0, 1'b1, 1'b1,
                     '{16'd0, 16'd0, 24'd0, 8'd0, 8'd0, emg_tfe_pkg::StatusOk}});
    // A mixed window left to the model.
    rows.push_back('{16'sd5, 1'b0, 1'b0, '0});
    rows.push_back('{-16'sd7, 1'b0, 1'b0, '0});
    rows.push_back('{16'sd0, 1'b0, 1'b0, '0});
    rows.push_back('{16'sd9, 1'b0, 1'b0, '0});
    rows.push_back('{-16'sd1, 1'b0, 1'b0, '0});
    rows.push_back('{16'sd1, 1'b1, 1'b0, '0});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) push_sample(rows[i].sample, rows[i].last, rows[i].typed, rows[i].result);
    push_i <= 1'b0;

    // Random part across several threshold settings, extremes included.
    // Writes with every bit set also check that the upper bits are dropped.
    set_thresholds(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_windows(250);
    set_thresholds(32'd0, 32'd0);
    random_windows(300);
    set_thresholds(32'd200, 32'd400);
    random_windows(300);
    set_thresholds($urandom_range(0, 32767), $urandom_range(0, 65535));
    random_windows(300);
    set_thresholds($urandom_range(0, 3000), $urandom_range(0, 6000));
    random_windows(350);
    calm = 1'b1;
    random_windows(300);
    push_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
